// ----- hw/rtl/cmfr_pkg.sv -----
// Shared constants, types and state codes for the collapse map face reducer.
package cmfr_pkg;

  // Fixed field widths
  localparam int unsigned IdxW    = 12;
  localparam int unsigned TargetW = 13;

  // Default table depth and reset value of the target register
  localparam int unsigned           MaxVertices = 4096;
  localparam logic [TargetW-1:0]    TargetReset = 13'd4096;

  // Command codes
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdFace = 1'b1;

  // Corner walker states
  typedef enum logic [1:0] {
    LnIdle,
    LnEval,
    LnFetch,
    LnDone
  } lane_state_e;

  // Top level sequencer states
  typedef enum logic {
    TopIdle,
    TopWalk
  } top_state_e;

  // Table write, broadcast to every lane copy
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [IdxW-1:0] data;
  } tbl_wr_t;

  // Lane control from the sequencer
  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctl_t;

  // Lane status back to the merge stage
  typedef struct packed {
    logic            done;
    logic            err;
    logic [IdxW-1:0] v;
  } lane_res_t;

endpackage

// ----- hw/rtl/cmfr_in_if.sv -----
// Input channel: load and face words with valid/ready handshake.
interface cmfr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] entry_index;
  logic [11:0] entry_value;
  logic [11:0] corner_a;
  logic [11:0] corner_b;
  logic [11:0] corner_c;

  modport source (
    output valid, command, entry_index, entry_value, corner_a, corner_b, corner_c,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, entry_value, corner_a, corner_b, corner_c,
    output ready
  );
endinterface

// ----- hw/rtl/cmfr_out_if.sv -----
// Output channel: mapped face words with valid/ready handshake.
interface cmfr_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] mapped_a;
  logic [11:0] mapped_b;
  logic [11:0] mapped_c;
  logic        walk_error;

  modport source (
    output valid, mapped_a, mapped_b, mapped_c, walk_error,
    input  ready
  );

  modport sink (
    input  valid, mapped_a, mapped_b, mapped_c, walk_error,
    output ready
  );
endinterface

// ----- hw/rtl/cmfr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module cmfr_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/cmfr_lane.sv -----
// Corner walker lane: follows one corner through its own copy of the collapse table.
module cmfr_lane #(
  parameter int unsigned MAX_VERTICES = cmfr_pkg::MaxVertices
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cmfr_pkg::TargetW-1:0]  target_i,
  input  cmfr_pkg::tbl_wr_t             wr_i,
  input  cmfr_pkg::lane_ctl_t           ctl_i,
  input  logic [cmfr_pkg::IdxW-1:0]     corner_i,
  output cmfr_pkg::lane_res_t           res_o
);
  import cmfr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned SW = $clog2(MAX_VERTICES + 1);

  lane_state_e     st_q, st_d;
  logic [IdxW-1:0] v_q, v_d;
  logic [SW-1:0]   steps_q, steps_d;
  logic            err_q, err_d;
  logic            rd_en;
  logic [IdxW-1:0] rdata;
  logic            wr_in_range;
  logic            below;
  logic            beyond;
  logic            at_limit;

  // Drop writes that fall outside the table
  assign wr_in_range = 32'(wr_i.addr) < 32'(MAX_VERTICES);

  cmfr_ram #(
    .WIDTH (IdxW),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_i.we && wr_in_range),
    .waddr_i (AW'(wr_i.addr)),
    .wdata_i (wr_i.data),
    .re_i    (rd_en),
    .raddr_i (AW'(v_q)),
    .rdata_o (rdata)
  );

  // Walk conditions on the current index
  assign below    = {1'b0, v_q} < target_i;
  assign beyond   = 32'(v_q) >= 32'(MAX_VERTICES);
  assign at_limit = steps_q == SW'(MAX_VERTICES);

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= LnIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    steps_q <= steps_d;
    err_q   <= err_d;
  end

  // Advance the walk: a table step issues the read in LnEval and follows the read data in LnFetch
  always_comb begin
    st_d    = st_q;
    v_d     = v_q;
    steps_d = steps_q;
    err_d   = err_q;
    rd_en   = 1'b0;
    case (st_q)
      LnIdle: begin
        if (ctl_i.start) begin
          steps_d = '0;
          err_d   = 1'b0;
          if (target_i == '0) begin
            v_d  = '0;
            st_d = LnDone;
          end else begin
            v_d  = corner_i;
            st_d = LnEval;
          end
        end
      end
      LnEval: begin
        if (below) begin
          st_d = LnDone;
        end else if (at_limit) begin
          err_d = 1'b1;
          st_d  = LnDone;
        end else if (beyond) begin
          v_d     = '0;
          steps_d = steps_q + 1'b1;
        end else begin
          rd_en = 1'b1;
          st_d  = LnFetch;
        end
      end
      LnFetch: begin
        v_d     = rdata;
        steps_d = steps_q + 1'b1;
        st_d    = LnEval;
      end
      LnDone: begin
        if (ctl_i.clear) begin
          st_d = LnIdle;
        end
      end
      default: begin
        st_d = LnIdle;
      end
    endcase
  end

  assign res_o.done = st_q == LnDone;
  assign res_o.err  = err_q;
  assign res_o.v    = v_q;

endmodule

// ----- hw/rtl/cmfr_merge.sv -----
// Merge stage: combines the three lane results, drops degenerate faces, holds the output word.
module cmfr_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmfr_pkg::lane_res_t res_a_i,
  input  cmfr_pkg::lane_res_t res_b_i,
  input  cmfr_pkg::lane_res_t res_c_i,
  input  logic                load_i,
  output logic                keep_o,
  output logic                free_o,
  cmfr_out_if.source          result_o
);
  import cmfr_pkg::*;

  logic            valid_q, valid_d;
  logic [IdxW-1:0] ma_q, mb_q, mc_q;
  logic            err_q;
  logic            err_any;
  logic            coincide;

  // Keep a face with distinct corners, or any face whose walk hit the limit
  assign err_any  = res_a_i.err | res_b_i.err | res_c_i.err;
  assign coincide = (res_a_i.v == res_b_i.v) || (res_b_i.v == res_c_i.v) ||
                    (res_c_i.v == res_a_i.v);
  assign keep_o   = err_any || !coincide;

  // Output register is free when empty or being taken this cycle
  assign free_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (result_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i && keep_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the word
  always_ff @(posedge clk_i) begin
    if (load_i && keep_o) begin
      ma_q  <= res_a_i.v;
      mb_q  <= res_b_i.v;
      mc_q  <= res_c_i.v;
      err_q <= err_any;
    end
  end

  assign result_o.valid      = valid_q;
  assign result_o.mapped_a   = ma_q;
  assign result_o.mapped_b   = mb_q;
  assign result_o.mapped_c   = mc_q;
  assign result_o.walk_error = err_q;

endmodule

// ----- hw/rtl/collapse_map_face_reducer_unit.sv -----
// Top level: collapse table lanes, face sequencer, merge stage and target register.
//
//   channel   dir  handshake      payload
//   item_i    in   valid/ready    command, entry_index, entry_value, corner_a/b/c
//   result_o  out  valid/ready    mapped_a/b/c, walk_error
//   cfg       in   cfg_we_i       cfg_wdata_i (target_count)
//
// A load word is written to every table copy when accepted. A face word is done once the longest
// corner chain is walked: each lane has one read port on its table copy and a registered read.
// Under a zero target the lanes skip the walk.
// Reset sets target_count to 4096; table contents are undefined until loaded.
// A new word is taken only while the lanes are idle; a waiting result holds a kept
// face at its final merge step, and with it the input.
module collapse_map_face_reducer_unit #(
  parameter int unsigned MAX_VERTICES = cmfr_pkg::MaxVertices
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cmfr_pkg::TargetW-1:0] cfg_wdata_i,
  cmfr_in_if.sink                      item_i,
  cmfr_out_if.source                   result_o
);
  import cmfr_pkg::*;

  top_state_e         st_q, st_d;
  logic [TargetW-1:0] target_q;
  logic               accept;
  logic               all_done;
  logic               keep;
  logic               free;
  logic               advance;
  tbl_wr_t            tbl_wr;
  lane_ctl_t          lane_ctl;
  lane_res_t          res_a, res_b, res_c;

  // Target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign item_i.ready = st_q == TopIdle;
  assign accept       = item_i.valid && item_i.ready;

  // Broadcast loads to every table copy
  assign tbl_wr.we   = accept && (item_i.command == CmdLoad);
  assign tbl_wr.addr = item_i.entry_index;
  assign tbl_wr.data = item_i.entry_value;

  assign all_done = res_a.done && res_b.done && res_c.done;
  assign advance  = (st_q == TopWalk) && all_done && (free || !keep);

  assign lane_ctl.start = accept && (item_i.command == CmdFace);
  assign lane_ctl.clear = advance;

  // Sequence faces through the lanes
  always_comb begin
    st_d = st_q;
    case (st_q)
      TopIdle: begin
        if (lane_ctl.start) begin
          st_d = TopWalk;
        end
      end
      TopWalk: begin
        if (advance) begin
          st_d = TopIdle;
        end
      end
      default: begin
        st_d = TopIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= TopIdle;
    end else begin
      st_q <= st_d;
    end
  end

  cmfr_lane #(.MAX_VERTICES(MAX_VERTICES)) u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .target_i (target_q),
    .wr_i     (tbl_wr),
    .ctl_i    (lane_ctl),
    .corner_i (item_i.corner_a),
    .res_o    (res_a)
  );

  cmfr_lane #(.MAX_VERTICES(MAX_VERTICES)) u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .target_i (target_q),
    .wr_i     (tbl_wr),
    .ctl_i    (lane_ctl),
    .corner_i (item_i.corner_b),
    .res_o    (res_b)
  );

  cmfr_lane #(.MAX_VERTICES(MAX_VERTICES)) u_lane_c (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .target_i (target_q),
    .wr_i     (tbl_wr),
    .ctl_i    (lane_ctl),
    .corner_i (item_i.corner_c),
    .res_o    (res_c)
  );

  cmfr_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_a_i  (res_a),
    .res_b_i  (res_b),
    .res_c_i  (res_c),
    .load_i   (advance),
    .keep_o   (keep),
    .free_o   (free),
    .result_o (result_o)
  );

endmodule
